### sv/phws_pkg.sv
`timescale 1ns / 1ps

package phws_pkg;

    // Field widths
    localparam int CHR_W = 5;
    localparam int POS_W = 13;
    localparam int CNT_W = 32;
    localparam int SUM_W = 44;

    // Default geometry of the count store
    localparam int POSITIONS_DEF   = 4096;
    localparam int CHROMOSOMES_DEF = 24;

    // Item opcodes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_Q_RD,
        ST_Q_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic {
        ALU_INC,
        ALU_ACC
    } alu_op_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

### sv/phws_store.sv
`timescale 1ns / 1ps

module phws_store #(
    parameter int POSITIONS   = phws_pkg::POSITIONS_DEF,
    parameter int CHROMOSOMES = phws_pkg::CHROMOSOMES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  phws_pkg::mem_ctl_t          mem_ctl,
    input  logic [$clog2(longint'(CHROMOSOMES) * longint'(POSITIONS))-1:0] mem_addr,
    input  logic [phws_pkg::CNT_W-1:0]  mem_wdata,
    output logic [phws_pkg::CNT_W-1:0]  mem_rdata,
    output logic                        clr_busy
);
    import phws_pkg::*;

    localparam longint unsigned DEPTH = longint'(CHROMOSOMES) * longint'(POSITIONS);
    localparam int AW = $clog2(DEPTH);

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rdata_reg;

    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic             we;
    logic [AW-1:0]    wa;
    logic [CNT_W-1:0] wd;

    // zeroing sweep after reset, one entry per cycle
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        we = clr_busy_reg || mem_ctl.wr_en;
        wa = clr_busy_reg ? clr_addr_reg : mem_addr;
        wd = clr_busy_reg ? '0 : mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (mem_ctl.rd_en) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;
    assign clr_busy  = clr_busy_reg;

endmodule

### sv/phws_alu.sv
`timescale 1ns / 1ps

module phws_alu (
    input  phws_pkg::alu_op_t           alu_op,
    input  logic [phws_pkg::SUM_W-1:0]  acc,
    input  logic [phws_pkg::CNT_W-1:0]  data,
    output logic [phws_pkg::SUM_W-1:0]  result
);
    import phws_pkg::*;

    logic [SUM_W-1:0] opa;
    logic [SUM_W-1:0] opb;
    logic [SUM_W:0]   sum;

    // one adder: counter increment or window accumulate, both saturating
    always_comb begin
        if (alu_op == ALU_INC) begin
            opa = SUM_W'(data);
            opb = SUM_W'(1);
        end else begin
            opa = acc;
            opb = SUM_W'(data);
        end
        sum = {1'b0, opa} + {1'b0, opb};
        if (alu_op == ALU_INC) begin
            result = (data == CNT_MAX) ? opa : sum[SUM_W-1:0];
        end else begin
            result = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
        end
    end

endmodule

### sv/phws_seq.sv
`timescale 1ns / 1ps

module phws_seq #(
    parameter int POSITIONS   = phws_pkg::POSITIONS_DEF,
    parameter int CHROMOSOMES = phws_pkg::CHROMOSOMES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [phws_pkg::CHR_W-1:0]  s_chromosome,
    input  logic [phws_pkg::POS_W-1:0]  s_position,
    input  logic [phws_pkg::POS_W-1:0]  s_window_end,
    input  logic                        clr_busy,
    output phws_pkg::mem_ctl_t          mem_ctl,
    output logic [$clog2(longint'(CHROMOSOMES) * longint'(POSITIONS))-1:0] mem_addr,
    output logic [phws_pkg::CNT_W-1:0]  mem_wdata,
    input  logic [phws_pkg::CNT_W-1:0]  mem_rdata,
    output phws_pkg::alu_op_t           alu_op,
    output logic [phws_pkg::SUM_W-1:0]  alu_acc,
    output logic [phws_pkg::CNT_W-1:0]  alu_data,
    input  logic [phws_pkg::SUM_W-1:0]  alu_result,
    output logic                        res_valid,
    input  logic                        res_take,
    output logic [phws_pkg::CHR_W-1:0]  res_chromosome,
    output logic [phws_pkg::POS_W-1:0]  res_start,
    output logic [phws_pkg::POS_W-1:0]  res_end,
    output logic [phws_pkg::SUM_W-1:0]  res_sum
);
    import phws_pkg::*;

    localparam longint unsigned DEPTH = longint'(CHROMOSOMES) * longint'(POSITIONS);
    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = $clog2(POSITIONS);
    localparam int CW  = ((PW > POS_W) ? PW : POS_W) + 1;
    localparam int RW  = PW + 1;
    localparam int CHW = CHR_W + 2;   // holds CHROMOSOMES up to 127

    seq_state_t state_reg, state_next;

    logic [CHR_W-1:0] chr_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] end_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             pend_reg, pend_next;

    logic          accept;
    logic          chr_ok, cnt_ok, q_ok;
    logic [CW-1:0] pos_c, end_c, pos_lim, idx_c, eff_end, win_len, sel_idx;
    logic [AW-1:0] base;

    assign accept = s_valid && s_ready;

    // item decode
    always_comb begin
        chr_ok  = {2'b00, s_chromosome} < CHW'(CHROMOSOMES);
        pos_c   = CW'(s_position);
        end_c   = CW'(s_window_end);
        pos_lim = CW'(POSITIONS);
        idx_c   = pos_c - CW'(1);
        cnt_ok  = chr_ok && (s_position != '0) && (idx_c < pos_lim);
        eff_end = (end_c > pos_lim) ? pos_lim : end_c;
        q_ok    = chr_ok && (pos_c < eff_end);
        win_len = eff_end - pos_c;
        sel_idx = (s_op == OP_COUNT) ? idx_c : pos_c;
        base    = AW'(s_chromosome) * AW'(POSITIONS);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (!clr_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_COUNT) begin
                        state_next = cnt_ok ? ST_CNT_RD : ST_IDLE;
                    end else begin
                        state_next = q_ok ? ST_Q_RD : ST_DONE;
                    end
                end
            end
            ST_CNT_RD:  state_next = ST_CNT_WR;
            ST_CNT_WR:  state_next = ST_IDLE;
            ST_Q_RD: begin
                if (rem_reg == RW'(1)) begin
                    state_next = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        mem_ctl.rd_en = (state_reg == ST_CNT_RD) || (state_reg == ST_Q_RD);
        mem_ctl.wr_en = (state_reg == ST_CNT_WR);
        alu_op        = (state_reg == ST_CNT_WR) ? ALU_INC : ALU_ACC;
        res_valid     = (state_reg == ST_DONE);
    end

    // datapath
    always_comb begin
        addr_next = addr_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        pend_next = (state_reg == ST_Q_RD);
        if (accept) begin
            addr_next = base + AW'(sel_idx);
            rem_next  = win_len[RW-1:0];
            acc_next  = '0;
        end else begin
            if (state_reg == ST_Q_RD) begin
                addr_next = addr_reg + AW'(1);
                rem_next  = rem_reg - RW'(1);
            end
            if (pend_reg) begin
                acc_next = alu_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        if (accept) begin
            chr_reg   <= s_chromosome;
            start_reg <= s_position;
            end_reg   <= s_window_end;
        end
    end

    assign mem_addr       = addr_reg;
    assign mem_wdata      = alu_result[CNT_W-1:0];
    assign alu_acc        = acc_reg;
    assign alu_data       = mem_rdata;
    assign res_chromosome = chr_reg;
    assign res_start      = start_reg;
    assign res_end        = end_reg;
    assign res_sum        = acc_reg;

endmodule

### sv/position_histogram_window_sum_core.sv
// Count word: accept, store read, store write; a dropped count ends at accept.
// Query word: accept, a store read per window entry (clipped to the store), a drain,
//   then the result waits on the output register (empty/out-of-range window: no reads).
// Single-port store, one entry per cycle; a finished query waits while m_valid is stalled.
// Reset (aresetn low, synchronous): a zeroing pass over all CHROMOSOMES*POSITIONS entries
//   (98304 at defaults) follows, with s_ready low until it ends.
`timescale 1ns / 1ps

module position_histogram_window_sum_core #(
    parameter int POSITIONS   = phws_pkg::POSITIONS_DEF,
    parameter int CHROMOSOMES = phws_pkg::CHROMOSOMES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [phws_pkg::CHR_W-1:0]  s_chromosome,
    input  logic [phws_pkg::POS_W-1:0]  s_position,
    input  logic [phws_pkg::POS_W-1:0]  s_window_end,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [phws_pkg::CHR_W-1:0]  m_out_chromosome,
    output logic [phws_pkg::POS_W-1:0]  m_out_start,
    output logic [phws_pkg::POS_W-1:0]  m_out_end,
    output logic [phws_pkg::SUM_W-1:0]  m_coverage_sum
);
    import phws_pkg::*;

    localparam longint unsigned DEPTH = longint'(CHROMOSOMES) * longint'(POSITIONS);
    localparam int AW = $clog2(DEPTH);

    // sequencer <-> store
    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    mem_addr;
    logic [CNT_W-1:0] mem_wdata;
    logic [CNT_W-1:0] mem_rdata;
    logic             clr_busy;

    // sequencer <-> shared adder
    alu_op_t          alu_op;
    logic [SUM_W-1:0] alu_acc;
    logic [CNT_W-1:0] alu_data;
    logic [SUM_W-1:0] alu_result;

    // finished query, waiting for the output register
    logic             res_valid;
    logic             res_take;
    logic [CHR_W-1:0] res_chromosome;
    logic [POS_W-1:0] res_start;
    logic [POS_W-1:0] res_end;
    logic [SUM_W-1:0] res_sum;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             load;
    logic [CHR_W-1:0] m_chr_reg;
    logic [POS_W-1:0] m_start_reg;
    logic [POS_W-1:0] m_end_reg;
    logic [SUM_W-1:0] m_sum_reg;

    phws_seq #(
        .POSITIONS   (POSITIONS),
        .CHROMOSOMES (CHROMOSOMES)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_chromosome   (s_chromosome),
        .s_position     (s_position),
        .s_window_end   (s_window_end),
        .clr_busy       (clr_busy),
        .mem_ctl        (mem_ctl),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata),
        .alu_op         (alu_op),
        .alu_acc        (alu_acc),
        .alu_data       (alu_data),
        .alu_result     (alu_result),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res_chromosome (res_chromosome),
        .res_start      (res_start),
        .res_end        (res_end),
        .res_sum        (res_sum)
    );

    phws_store #(
        .POSITIONS   (POSITIONS),
        .CHROMOSOMES (CHROMOSOMES)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .clr_busy  (clr_busy)
    );

    // shared saturating adder: +1 for counts, running sum for queries
    phws_alu u_alu (
        .alu_op (alu_op),
        .acc    (alu_acc),
        .data   (alu_data),
        .result (alu_result)
    );

    // The output register frees the sequencer once a result is handed over,
    // so the next word is taken while the result still waits on m_ready.
    assign res_take = !m_valid_reg || m_ready;
    assign load     = res_valid && res_take;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_chr_reg   <= res_chromosome;
            m_start_reg <= res_start;
            m_end_reg   <= res_end;
            m_sum_reg   <= res_sum;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_chromosome = m_chr_reg;
    assign m_out_start      = m_start_reg;
    assign m_out_end        = m_end_reg;
    assign m_coverage_sum   = m_sum_reg;

endmodule

### sv/phws_checker.sv
`timescale 1ns / 1ps

module phws_checker #(
    parameter int CHROMOSOMES = phws_pkg::CHROMOSOMES_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_op,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [phws_pkg::CHR_W-1:0]  m_out_chromosome,
    input logic [phws_pkg::POS_W-1:0]  m_out_start,
    input logic [phws_pkg::POS_W-1:0]  m_out_end,
    input logic [phws_pkg::SUM_W-1:0]  m_coverage_sum
);
    import phws_pkg::*;

    // result holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coverage_sum) && $stable(m_out_start))
        else $error("result word changed while stalled");

    // store is being zeroed right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input ready during the zeroing pass");

    // an accepted query always moves the sequencer out of idle, dropping s_ready
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_QUERY) |=> !s_ready)
        else $error("ready right after a query");

    a_empty_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_out_start < m_out_end) |-> m_coverage_sum == '0)
        else $error("nonzero sum for an empty window");

    a_bad_chromosome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({2'b00, m_out_chromosome} >= (CHR_W + 2)'(CHROMOSOMES))
        |-> m_coverage_sum == '0)
        else $error("nonzero sum for an unknown chromosome");

endmodule

bind position_histogram_window_sum_core phws_checker #(
    .CHROMOSOMES (CHROMOSOMES)
) u_phws_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_op             (s_op),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_out_chromosome (m_out_chromosome),
    .m_out_start      (m_out_start),
    .m_out_end        (m_out_end),
    .m_coverage_sum   (m_coverage_sum)
);
